@@ rtl/pwsv_pkg.sv @@
// Package: constants, types and fixed-point helpers of the star vertex core
`default_nettype none
package pwsv_pkg;

    localparam int WaveSamples = 576;
    localparam int IdxW        = $clog2(WaveSamples);
    localparam int RegIdxW     = 3;
    localparam int RadW        = 18;
    localparam int RBase       = 2867;
    localparam int RDrop       = 819;
    localparam int Scale04     = 26214;
    localparam int Turn628     = 65503;

    localparam logic [RegIdxW-1:0] REG_WAVE_PARAM = 3'd0;
    localparam logic [RegIdxW-1:0] REG_ASPECT_X   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_ASPECT_Y   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_CENTER_X   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_CENTER_Y   = 3'd4;
    localparam logic [RegIdxW-1:0] REG_PHASE      = 3'd5;

    // Item handed from the front to the back part
    typedef struct packed {
        logic signed [RadW-1:0] radius;
        logic [15:0]            angle;
        logic [15:0]            blend_phase;
        logic                   blend;
        logic                   last;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_SQ,
        ST_W_T,
        ST_W_U,
        ST_W_Z,
        ST_A_SQ,
        ST_A_T,
        ST_A_U,
        ST_A_Z
    } t_back_state;

endpackage
`default_nettype wire

@@ rtl/polar_wave_star_vertex_core.sv @@
// Top level of the star vertex core: registers, front, queue and back part
// The back part takes a new vertex only after the previous result has been accepted; its shared
// multiply sequencer runs two or three sine polynomials (three when blending) plus scaling.
// Reset: synchronous active-low; clears the vertex index, queue, handshakes and
// loads the register defaults.
`default_nettype none
module polar_wave_star_vertex_core
    import pwsv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [RegIdxW-1:0]    i_cfg_index,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [15:0]    i_pcm_sample,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [15:0]         o_vertex_x,
    output logic signed [15:0]         o_vertex_y,
    output logic                       o_last_vertex
);
    logic signed [15:0] r_wave_param, r_aspect_x, r_aspect_y, r_center_x, r_center_y;
    logic [15:0]        r_phase_offset;
    logic fq_v, fq_r, qb_v, qb_r;
    t_job fq_job, qb_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_param <= '0; r_aspect_x <= 16'sd4096; r_aspect_y <= 16'sd4096;
            r_center_x <= '0; r_center_y <= '0; r_phase_offset <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WAVE_PARAM: r_wave_param   <= i_cfg_data;
                REG_ASPECT_X:   r_aspect_x     <= i_cfg_data;
                REG_ASPECT_Y:   r_aspect_y     <= i_cfg_data;
                REG_CENTER_X:   r_center_x     <= i_cfg_data;
                REG_CENTER_Y:   r_center_y     <= i_cfg_data;
                REG_PHASE:      r_phase_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pwsv_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pcm_sample,
        .i_wave_param(r_wave_param), .i_phase_offset(r_phase_offset),
        .o_job_valid(fq_v), .i_job_ready(fq_r), .o_job(fq_job)
    );

    pwsv_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fq_v), .o_ready(fq_r), .i_job(fq_job),
        .o_valid(qb_v), .i_ready(qb_r), .o_job(qb_job)
    );

    pwsv_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(qb_v), .o_job_ready(qb_r), .i_job(qb_job),
        .i_aspect_x(r_aspect_x), .i_aspect_y(r_aspect_y),
        .i_center_x(r_center_x), .i_center_y(r_center_y),
        .o_valid, .i_ready, .o_vertex_x, .o_vertex_y, .o_last_vertex
    );
endmodule
`default_nettype wire

@@ rtl/pwsv_front.sv @@
// Front part: index counter, radius, angle and blend decision per sample
`default_nettype none
module pwsv_front
    import pwsv_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_pcm_sample,
    input  wire logic signed [15:0]  i_wave_param,
    input  wire logic [15:0]         i_phase_offset,
    output logic                     o_job_valid,
    input  wire logic                i_job_ready,
    output t_job                     o_job
);
    localparam int                  N        = (WaveSamples > 1) ? WaveSamples : 2;
    localparam logic [IdxW-1:0]     Last     = IdxW'(N - 1);
    localparam logic [31:0]         NLim     = 32'(N * 4096);
    localparam logic [15:0]         AngDiv   = 16'(N - 1);
    localparam logic [15:0]         AngStepQ = 16'(Turn628 / (N - 1));
    localparam logic [15:0]         AngStepR = 16'(Turn628 % (N - 1));
    localparam logic [15:0]         AngRem0  = 16'((N - 1) / 2);
    localparam logic [15:0]         MpDiv    = 16'(N);
    localparam logic [15:0]         MpStepQ  = 16'((5 * 65536) / N);
    localparam logic [15:0]         MpStepR  = 16'((5 * 65536) % N);
    localparam logic [15:0]         MpRem0   = 16'(N / 2);

    // stage 0: capture sample, stage 1: radius products, stage 2: job out
    logic [IdxW-1:0]         r_idx, n_idx;
    logic [1:0]              r_st;
    logic signed [15:0]      r_smp;
    logic signed [RadW-1:0]  r_rad;
    logic [IdxW-1:0]         r_i;
    logic                    r_jv;
    t_job                    r_job;
    // running quotient and remainder of the angle and blend-phase divisions
    logic [15:0]             r_ang_acc, r_ang_rem, r_mp_acc, r_mp_rem;
    logic [15:0]             r_ang_q, r_mp_q;

    logic signed [31:0]      prod;
    logic signed [RadW-1:0]  rad;
    logic [31:0]             ir;
    logic [15:0]             ang_sum, mp_sum;
    logic [15:0]             n_ang_acc, n_ang_rem, n_mp_acc, n_mp_rem;
    logic                    ang_wrap, mp_wrap;

    assign o_ready     = (r_st == 2'd0) && !r_jv;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    assign prod  = 32'(r_smp) * 32'(Scale04) + 32'sd262144;
    assign rad   = RadW'(RBase) + RadW'(prod >>> 19) + RadW'(i_wave_param);
    assign ir    = 32'(r_i) * 32'($unsigned(r_rad));
    assign n_idx = (r_idx >= Last) ? '0 : r_idx + 1'b1;

    assign ang_sum   = r_ang_rem + AngStepR;
    assign ang_wrap  = (ang_sum >= AngDiv);
    assign n_ang_rem = ang_wrap ? ang_sum - AngDiv : ang_sum;
    assign n_ang_acc = r_ang_acc + AngStepQ + {15'd0, ang_wrap};
    assign mp_sum    = r_mp_rem + MpStepR;
    assign mp_wrap   = (mp_sum >= MpDiv);
    assign n_mp_rem  = mp_wrap ? mp_sum - MpDiv : mp_sum;
    assign n_mp_acc  = r_mp_acc + MpStepQ + {15'd0, mp_wrap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= 2'd0;
            r_jv      <= 1'b0;
            r_idx     <= '0;
            r_ang_acc <= '0;
            r_ang_rem <= AngRem0;
            r_mp_acc  <= '0;
            r_mp_rem  <= MpRem0;
        end else begin
            if (r_jv && i_job_ready) r_jv <= 1'b0;
            case (r_st)
                2'd0: begin
                    if (i_valid && o_ready) begin
                        r_smp <= i_pcm_sample;
                        r_i   <= (r_idx >= Last) ? Last : r_idx;
                        r_job.last <= (r_idx >= Last);
                        r_idx <= n_idx;
                        r_ang_q <= r_ang_acc;
                        r_mp_q  <= r_mp_acc;
                        if (r_idx >= Last) begin
                            r_ang_acc <= '0;
                            r_ang_rem <= AngRem0;
                            r_mp_acc  <= '0;
                            r_mp_rem  <= MpRem0;
                        end else begin
                            r_ang_acc <= n_ang_acc;
                            r_ang_rem <= n_ang_rem;
                            r_mp_acc  <= n_mp_acc;
                            r_mp_rem  <= n_mp_rem;
                        end
                        r_st  <= 2'd1;
                    end
                end
                2'd1: begin
                    r_rad     <= rad;
                    r_st      <= 2'd2;
                end
                2'd2: begin
                    r_job.radius      <= r_rad;
                    r_job.angle       <= r_ang_q + i_phase_offset;
                    r_job.blend_phase <= r_mp_q;
                    r_job.blend       <= (r_rad == '0) ||
                                         (!r_rad[RadW-1] && (ir < NLim));
                    r_jv <= 1'b1;
                    r_st <= 2'd0;
                end
                default: r_st <= 2'd0;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/pwsv_queue.sv @@
// Two-entry queue between front and back parts
`default_nettype none
module pwsv_queue
    import pwsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/pwsv_back.sv @@
// Back part: sine polynomial sequencer, blend, scaling and saturation
`default_nettype none
module pwsv_back
    import pwsv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    output logic                    o_job_ready,
    input  t_job                    i_job,
    input  wire logic signed [15:0] i_aspect_x,
    input  wire logic signed [15:0] i_aspect_y,
    input  wire logic signed [15:0] i_center_x,
    input  wire logic signed [15:0] i_center_y,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_vertex_x,
    output logic signed [15:0]      o_vertex_y,
    output logic                    o_last_vertex
);
    t_back_state r_state, n_state;
    t_job        r_job;
    logic        r_ph;          // 0 cosine, 1 sine of angle
    logic [1:0]  r_fin;
    logic signed [RadW-1:0] r_rad;
    logic [16:0] r_z, r_z2, r_t, r_u;
    logic        r_neg;
    logic signed [16:0] r_cos, r_sin;
    logic signed [35:0] r_p;
    logic        r_ov;
    logic signed [15:0] r_x, r_y;
    logic        r_last;

    logic [15:0] p_sel;
    logic [15:0] ang_c;
    logic [1:0]  q;
    logic [16:0] zz;
    logic [33:0] m;
    logic [16:0] s_val;
    logic signed [16:0] s_sgn;
    logic signed [17:0] w_dif;
    logic [31:0] w_add;
    logic        busy_fin;
    logic signed [51:0] fin_p;
    logic signed [15:0] fin_asp, fin_ctr;
    logic signed [27:0] fin_r;
    logic signed [27:0] fin_s;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid && !busy_fin && !r_ov)
                n_state = i_job.blend ? ST_W_SQ : ST_A_SQ;
            ST_W_SQ: n_state = ST_W_T;
            ST_W_T:  n_state = ST_W_U;
            ST_W_U:  n_state = ST_W_Z;
            ST_W_Z:  n_state = ST_A_SQ;
            ST_A_SQ: n_state = ST_A_T;
            ST_A_T:  n_state = ST_A_U;
            ST_A_U:  n_state = ST_A_Z;
            ST_A_Z:  n_state = r_ph ? ST_IDLE : ST_A_SQ;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_job_ready = (r_state == ST_IDLE) && !busy_fin && !r_ov;

    always_comb begin
        p_sel = i_job.blend ? i_job.blend_phase + 16'h4000 : i_job.angle + 16'h4000;
        q     = p_sel[15:14];
        zz    = q[0] ? 17'(32768) - {2'b0, p_sel[13:0], 1'b0}
                     : {2'b0, p_sel[13:0], 1'b0};
        case (r_state)
            ST_W_SQ, ST_A_SQ: m = 34'(r_z) * 34'(r_z);
            ST_W_T,  ST_A_T:  m = 34'(r_z2) * 34'(2320);
            ST_W_U,  ST_A_U:  m = 34'(r_z2) * 34'(r_t);
            ST_W_Z,  ST_A_Z:  m = 34'(r_z) * 34'(r_u);
            default:          m = '0;
        endcase
        s_val = 17'(m >> 15);
        s_sgn = r_neg ? -s_val : s_val;
    end

    // blend weight w = (32768 - cos) / 2 and its share of the radius drop
    assign ang_c = r_job.angle + 16'h4000;
    assign w_dif = 18'sd32768 - 18'(s_sgn);
    assign w_add = (32'(RDrop) * {16'd0, w_dif[16:1]} + 32'd16384) >> 15;

    // final multiplies: r*trig, then *aspect, round, add centre
    assign busy_fin = (r_fin != 2'd0);
    assign fin_asp  = (r_fin == 2'd2) ? i_aspect_y : i_aspect_x;
    assign fin_ctr  = (r_fin == 2'd2) ? i_center_x : i_center_y;
    assign fin_p    = 52'(r_p) * 52'(fin_asp) + 52'sd67108864;
    assign fin_r    = 28'(fin_p >>> 27);
    assign fin_s    = fin_r + 28'(fin_ctr);

    function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
        if (v > 28'sd32767)       return 16'sh7fff;
        else if (v < -28'sd32768) return -16'sh8000;
        else                      return 16'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: if (o_job_ready && i_job_valid) begin
                    r_job <= i_job;
                    r_rad <= i_job.radius;
                    r_ph  <= 1'b0;
                    r_z   <= zz;
                    r_neg <= q[1];
                end
                ST_W_SQ, ST_A_SQ: r_z2 <= s_val;
                ST_W_T, ST_A_T:   r_t  <= 17'(21024) - s_val;
                ST_W_U, ST_A_U:   r_u  <= 17'(51472) - s_val;
                ST_W_Z: begin
                    r_rad <= r_rad - RadW'(RDrop) + RadW'(w_add);
                    r_z   <= ang_c[14] ?
                        17'(32768) - {2'b0, ang_c[13:0], 1'b0}
                        : {2'b0, ang_c[13:0], 1'b0};
                    r_neg <= ang_c[15];
                end
                ST_A_Z: begin
                    if (!r_ph) begin
                        r_cos <= s_sgn;
                        r_ph  <= 1'b1;
                        r_z   <= r_job.angle[14] ?
                            17'(32768) - {2'b0, r_job.angle[13:0], 1'b0}
                            : {2'b0, r_job.angle[13:0], 1'b0};
                        r_neg <= r_job.angle[15];
                    end else begin
                        r_sin <= s_sgn;
                        r_fin <= 2'd1;
                    end
                end
                default: ;
            endcase
            case (r_fin)
                2'd1: begin
                    r_p   <= 36'(r_rad) * 36'(r_cos);
                    r_fin <= 2'd2;
                end
                2'd2: begin
                    r_x   <= sat16(fin_s);
                    r_p   <= 36'(r_rad) * 36'(r_sin);
                    r_fin <= 2'd3;
                end
                2'd3: begin
                    r_y    <= sat16(fin_s);
                    r_last <= r_job.last;
                    r_ov   <= 1'b1;
                    r_fin  <= 2'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_vertex_x    = r_x;
    assign o_vertex_y    = r_y;
    assign o_last_vertex = r_last;
endmodule
`default_nettype wire

@@ rtl/pwsv_checker.sv @@
// Port-level checker for the star vertex core, with its bind
`default_nettype none
module pwsv_checker
    import pwsv_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_vertex_x,
    input wire logic        o_last_vertex
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vertex_x))
        else $error("result dropped while stalled");
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_last_vertex))
        else $error("last flag changed while stalled");
endmodule

bind polar_wave_star_vertex_core pwsv_checker u_pwsv_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_vertex_x, .o_last_vertex
);
`default_nettype wire

@@ sim/polar_wave_star_vertex_core_tb.sv @@
// Testbench of the star vertex core: directed table, register corner cases, then random frames, self-checked
`timescale 1ns / 100ps
`default_nettype none
module polar_wave_star_vertex_core_tb;
    import pwsv_pkg::*;

    typedef struct {
        logic [15:0] vx;
        logic [15:0] vy;
        logic        last;
    } t_vertex;

    typedef struct {
        logic [15:0] sample;
        bit          known;
        logic [15:0] vx;
        logic [15:0] vy;
    } t_stim_row;

    localparam int NumRandom  = 1600;
    localparam int WatchLimit = 20000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [RegIdxW-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] pcm;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic last_v;

    logic [15:0] shadow_reg [6];
    int unsigned vert_idx;
    t_vertex expected_vertices[$];
    int errors;
    int idle_cycles;
    bit idle_free;
    bit stim_done;

    polar_wave_star_vertex_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_pcm_sample(pcm),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_vertex_x(vx), .o_vertex_y(vy), .o_last_vertex(last_v)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint quarter_sine(longint z);
        longint z2, t, u;
        z2 = (z * z) >> 15;
        t  = 21024 - ((z2 * 2320) >> 15);
        u  = 51472 - ((z2 * t) >> 15);
        return (z * u) >> 15;
    endfunction

    function automatic longint sine_q15(logic [15:0] p);
        longint z, s;
        z = longint'(p[13:0]) << 1;
        s = p[14] ? quarter_sine(32768 - z) : quarter_sine(z);
        return p[15] ? -s : s;
    endfunction

    function automatic longint cosine_q15(logic [15:0] p);
        logic [15:0] q;
        q = p + 16'd16384;
        return sine_q15(q);
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_vertex star_vertex(logic [15:0] sample);
        t_vertex res;
        longint n, i, r, w, cv, sv;
        logic [15:0] angle, mp;
        bit blend;
        n = WaveSamples;
        i = vert_idx;
        res.last = (i >= n - 1);
        r = RBase + round_shift(longint'($signed(sample)) * Scale04, 19)
            + longint'($signed(shadow_reg[REG_WAVE_PARAM]));
        angle = 16'((i * Turn628 + (n - 1) / 2) / (n - 1) + shadow_reg[REG_PHASE]);
        if (r == 0) blend = 1'b1;
        else if (r < 0) blend = 1'b0;
        else blend = (i * r) < n * 4096;
        if (blend) begin
            mp = 16'((i * 5 * 65536 + n / 2) / n);
            w = (32768 - cosine_q15(mp)) >> 1;
            r = r - RDrop + ((RDrop * w + 16384) >> 15);
        end
        cv = cosine_q15(angle);
        sv = sine_q15(angle);
        res.vx = clamp16(round_shift(r * cv * longint'($signed(shadow_reg[REG_ASPECT_Y])), 27)
                         + longint'($signed(shadow_reg[REG_CENTER_X])));
        res.vy = clamp16(round_shift(r * sv * longint'($signed(shadow_reg[REG_ASPECT_X])), 27)
                         + longint'($signed(shadow_reg[REG_CENTER_Y])));
        vert_idx = res.last ? 0 : vert_idx + 1;
        return res;
    endfunction

    function automatic bit idle_now();
        return !idle_free && ($urandom_range(99) < 33);
    endfunction

    task automatic write_reg(logic [RegIdxW-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < 6) shadow_reg[idx] = data;
        @(posedge clk);
    endtask

    task automatic send_sample(logic [15:0] sample, bit known, logic [15:0] ex,
                               logic [15:0] ey);
        t_vertex e;
        while (idle_now()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pcm      <= sample;
        do @(posedge clk); while (!in_ready);
        e = star_vertex(sample);
        if (known) begin
            e.vx = ex;
            e.vy = ey;
        end
        expected_vertices.push_back(e);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // zero sample at vertex 0: r = 2867 blended by w = 0 -> 2048, cos 1, sin 0
    t_stim_row directed[] = '{
        '{16'h0000, 1'b1, 16'd2048, 16'd0},
        '{16'h7FFF, 1'b0, 16'd0, 16'd0},
        '{16'h8000, 1'b0, 16'd0, 16'd0},
        '{16'h0001, 1'b0, 16'd0, 16'd0},
        '{16'hFFFF, 1'b0, 16'd0, 16'd0},
        '{16'h5555, 1'b0, 16'd0, 16'd0},
        '{16'hAAAA, 1'b0, 16'd0, 16'd0},
        '{16'h4000, 1'b0, 16'd0, 16'd0}
    };

    always @(posedge clk) begin
        t_vertex e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_vertices.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d", vx, vy);
                    errors++;
                end else begin
                    e = expected_vertices.pop_front();
                    if (vx !== e.vx) begin
                        $error("vertex_x expected %0d actual %0d", $signed(e.vx), vx);
                        errors++;
                    end
                    if (vy !== e.vy) begin
                        $error("vertex_y expected %0d actual %0d", $signed(e.vy), vy);
                        errors++;
                    end
                    if (last_v !== e.last) begin
                        $error("last_vertex expected %0d actual %0d", e.last, last_v);
                        errors++;
                    end
                end
            end
            out_ready <= !idle_now();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (!stim_done || expected_vertices.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int k;
        errors = 0;
        idle_free = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pcm = '0;
        vert_idx = 0;
        shadow_reg = '{16'd0, 16'd4096, 16'd4096, 16'd0, 16'd0, 16'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[j])
            send_sample(directed[j].sample, directed[j].known, directed[j].vx, directed[j].vy);
        drain();

        // extreme register settings, including negative radius bias and saturation
        write_reg(REG_WAVE_PARAM, 16'h8000);
        write_reg(REG_ASPECT_X, 16'h7FFF);
        write_reg(REG_ASPECT_Y, 16'h8000);
        write_reg(REG_CENTER_X, 16'h7FFF);
        write_reg(REG_CENTER_Y, 16'h8000);
        write_reg(REG_PHASE, 16'hFFFF);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        for (k = 0; k < 8; k++) send_sample(directed[k].sample, 1'b0, '0, '0);
        drain();
        // radius bias that drives r to exactly zero for a zero sample
        write_reg(REG_WAVE_PARAM, 16'(-2867));
        write_reg(REG_ASPECT_X, 16'h7FFF);
        write_reg(REG_ASPECT_Y, 16'h7FFF);
        write_reg(REG_CENTER_X, 16'h0000);
        write_reg(REG_CENTER_Y, 16'h0000);
        for (k = 0; k < 4; k++) send_sample(16'h0000, 1'b0, '0, '0);
        drain();

        for (k = 0; k < NumRandom; k++) begin
            if (k % 300 == 299) begin
                drain();
                write_reg(REG_WAVE_PARAM, ($urandom_range(3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(2000)));
                write_reg(REG_ASPECT_X, 16'($urandom));
                write_reg(REG_ASPECT_Y, 16'($urandom));
                write_reg(REG_CENTER_X, 16'($urandom));
                write_reg(REG_CENTER_Y, 16'($urandom));
                write_reg(REG_PHASE, 16'($urandom));
            end
            idle_free = (k >= 600 && k < 900);
            send_sample(16'($urandom), 1'b0, '0, '0);
        end
        idle_free = 1'b0;
        stim_done = 1'b1;
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ polar_wave_star_vertex_core.f @@
rtl/pwsv_pkg.sv
rtl/pwsv_front.sv
rtl/pwsv_queue.sv
rtl/pwsv_back.sv
rtl/polar_wave_star_vertex_core.sv
rtl/pwsv_checker.sv
sim/polar_wave_star_vertex_core_tb.sv
